[sv/tlb2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb2_pkg
// Shared sizes, codes and control types of the two-level TLB hierarchy.
// ----------------------------------------------------------------------------
package tlb2_pkg;

  localparam int L1_LINES    = 16;
  localparam int L2_LINES    = 64;
  localparam int VPN_BITS    = 36;
  localparam int PPN_BITS    = 32;
  localparam int OFFSET_BITS = 12;

  localparam int L1_IDX_W = $clog2(L1_LINES);
  localparam int L2_IDX_W = $clog2(L2_LINES);
  localparam int L1_TAG_W = VPN_BITS - L1_IDX_W;
  localparam int L2_TAG_W = VPN_BITS - L2_IDX_W;

  typedef enum logic [1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_FILL      = 2'd1,
    REQ_FLUSH     = 2'd2
  } tlb2_req_e;

  typedef enum logic [1:0] {
    FLUSH_INST_L1 = 2'd0,
    FLUSH_DATA_L1 = 2'd1,
    FLUSH_L2      = 2'd2
  } tlb2_flush_e;

  typedef enum logic [2:0] {
    ST_L1_HIT  = 3'd0,
    ST_L2_HIT  = 3'd1,
    ST_MISS    = 3'd2,
    ST_FILLED  = 3'd3,
    ST_FLUSHED = 3'd4
  } tlb2_status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } tlb2_fsm_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } tlb2_cmd_t;

endpackage

[sv/tlb2_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb2_ctrl
// Sequencer: takes a request in idle, runs one execute cycle, returns to idle.
// ----------------------------------------------------------------------------
module tlb2_ctrl
  import tlb2_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output tlb2_cmd_t cmd_o
);

  tlb2_fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy_o      = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.exec)
    else $error("execute cycle did not follow a capture");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> !cmd_o.exec)
    else $error("execute lasted more than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.exec))
    else $error("capture while executing");

endmodule

[sv/tlb2_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb2_datapath
// Instruction L1, data L1 and shared L2 tables, lookup, fill, flush and the
// result register.
// ----------------------------------------------------------------------------
module tlb2_datapath
  import tlb2_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlb2_cmd_t              cmd_i,
  input  logic [1:0]             req_type_i,
  input  logic                   access_kind_i,
  input  logic [VPN_BITS-1:0]    virt_page_i,
  input  logic [OFFSET_BITS-1:0] page_offset_i,
  input  logic [PPN_BITS-1:0]    walk_page_i,
  input  logic [1:0]             flush_target_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic                   hit_o,
  output logic [PPN_BITS-1:0]    phys_page_o,
  output logic [OFFSET_BITS-1:0] offset_out_o
);

  // Captured request
  logic [1:0]             req_q;
  logic                   kind_q;
  logic [VPN_BITS-1:0]    vpn_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic [PPN_BITS-1:0]    walk_q;
  logic [1:0]             target_q;

  // L1 tables in flops
  logic [L1_LINES-1:0] il1_valid_q, il1_valid_d;
  logic [L1_LINES-1:0] dl1_valid_q, dl1_valid_d;
  logic [L1_TAG_W-1:0] il1_tag_q  [L1_LINES];
  logic [PPN_BITS-1:0] il1_page_q [L1_LINES];
  logic [L1_TAG_W-1:0] dl1_tag_q  [L1_LINES];
  logic [PPN_BITS-1:0] dl1_page_q [L1_LINES];

  // L2 table: valid bits in flops, tag and page in memory
  logic [L2_LINES-1:0] l2_valid_q, l2_valid_d;
  logic [L2_TAG_W-1:0] l2_tag_mem  [L2_LINES];
  logic [PPN_BITS-1:0] l2_page_mem [L2_LINES];
  logic [L2_TAG_W-1:0] l2_tag_rd_q;
  logic [PPN_BITS-1:0] l2_page_rd_q;

  logic                   res_valid_q, res_valid_d;
  logic [2:0]             status_q, status_d;
  logic                   hit_q, hit_d;
  logic [PPN_BITS-1:0]    page_q, page_d;
  logic [OFFSET_BITS-1:0] offout_q, offout_d;

  logic [L1_IDX_W-1:0] l1_idx;
  logic [L2_IDX_W-1:0] l2_idx;
  logic [L1_TAG_W-1:0] l1_tag;
  logic [L2_TAG_W-1:0] l2_tag;
  logic [VPN_BITS-1:0] victim_vpn;
  logic [L1_IDX_W-1:0] victim_idx;
  logic [L1_TAG_W-1:0] victim_tag;

  logic                own_valid, oth_valid;
  logic [L1_TAG_W-1:0] own_tag, oth_tag;
  logic [PPN_BITS-1:0] own_page;
  logic                l1_hit, l2_hit, victim_hit;

  logic                l1_we, l2_we;
  logic [PPN_BITS-1:0] l1_wpage;

  assign l1_idx     = vpn_q[L1_IDX_W-1:0];
  assign l2_idx     = vpn_q[L2_IDX_W-1:0];
  assign l1_tag     = vpn_q[VPN_BITS-1:L1_IDX_W];
  assign l2_tag     = vpn_q[VPN_BITS-1:L2_IDX_W];
  assign victim_vpn = {l2_tag_rd_q, l2_idx};
  assign victim_idx = victim_vpn[L1_IDX_W-1:0];
  assign victim_tag = victim_vpn[VPN_BITS-1:L1_IDX_W];

  always_comb begin
    if (kind_q) begin
      own_valid = dl1_valid_q[l1_idx];
      own_tag   = dl1_tag_q[l1_idx];
      own_page  = dl1_page_q[l1_idx];
      oth_valid = il1_valid_q[victim_idx];
      oth_tag   = il1_tag_q[victim_idx];
    end else begin
      own_valid = il1_valid_q[l1_idx];
      own_tag   = il1_tag_q[l1_idx];
      own_page  = il1_page_q[l1_idx];
      oth_valid = dl1_valid_q[victim_idx];
      oth_tag   = dl1_tag_q[victim_idx];
    end
  end

  assign l1_hit     = own_valid && (own_tag == l1_tag);
  assign l2_hit     = l2_valid_q[l2_idx] && (l2_tag_rd_q == l2_tag);
  assign victim_hit = l2_valid_q[l2_idx] && oth_valid && (oth_tag == victim_tag);

  always_comb begin
    il1_valid_d = il1_valid_q;
    dl1_valid_d = dl1_valid_q;
    l2_valid_d  = l2_valid_q;
    l1_we       = 1'b0;
    l2_we       = 1'b0;
    l1_wpage    = walk_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    hit_d       = hit_q;
    page_d      = page_q;
    offout_d    = offout_q;
    if (cmd_i.exec) begin
      case (req_q)
        REQ_TRANSLATE: begin
          res_valid_d = 1'b1;
          if (l1_hit) begin
            status_d = ST_L1_HIT;
            hit_d    = 1'b1;
            page_d   = own_page;
            offout_d = off_q;
          end else if (l2_hit) begin
            status_d = ST_L2_HIT;
            hit_d    = 1'b1;
            page_d   = l2_page_rd_q;
            offout_d = off_q;
            l1_we    = 1'b1;
            l1_wpage = l2_page_rd_q;
          end else begin
            status_d = ST_MISS;
            hit_d    = 1'b0;
            page_d   = '0;
            offout_d = '0;
          end
        end
        REQ_FILL: begin
          res_valid_d = 1'b1;
          status_d    = ST_FILLED;
          hit_d       = 1'b0;
          page_d      = walk_q;
          offout_d    = off_q;
          l1_we       = 1'b1;
          l2_we       = 1'b1;
          // drop the evicted page from the other L1
          if (victim_hit) begin
            if (kind_q) begin
              il1_valid_d[victim_idx] = 1'b0;
            end else begin
              dl1_valid_d[victim_idx] = 1'b0;
            end
          end
          l2_valid_d[l2_idx] = 1'b1;
        end
        REQ_FLUSH: begin
          res_valid_d = 1'b1;
          status_d    = ST_FLUSHED;
          hit_d       = 1'b0;
          page_d      = '0;
          offout_d    = '0;
          case (target_q)
            FLUSH_INST_L1: il1_valid_d = '0;
            FLUSH_DATA_L1: dl1_valid_d = '0;
            FLUSH_L2:      l2_valid_d  = '0;
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      if (l1_we) begin
        if (kind_q) begin
          dl1_valid_d[l1_idx] = 1'b1;
        end else begin
          il1_valid_d[l1_idx] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      il1_valid_q <= '0;
      dl1_valid_q <= '0;
      l2_valid_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      il1_valid_q <= il1_valid_d;
      dl1_valid_q <= dl1_valid_d;
      l2_valid_q  <= l2_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hit_q    <= hit_d;
    page_q   <= page_d;
    offout_q <= offout_d;
    if (cmd_i.capture) begin
      req_q    <= req_type_i;
      kind_q   <= access_kind_i;
      vpn_q    <= virt_page_i;
      off_q    <= page_offset_i;
      walk_q   <= walk_page_i;
      target_q <= flush_target_i;
    end
    if (l1_we) begin
      if (kind_q) begin
        dl1_tag_q[l1_idx]  <= l1_tag;
        dl1_page_q[l1_idx] <= l1_wpage;
      end else begin
        il1_tag_q[l1_idx]  <= l1_tag;
        il1_page_q[l1_idx] <= l1_wpage;
      end
    end
  end

  // L2 memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (l2_we) begin
      l2_tag_mem[l2_idx]  <= l2_tag;
      l2_page_mem[l2_idx] <= walk_q;
    end
    if (cmd_i.capture) begin
      l2_tag_rd_q  <= l2_tag_mem[virt_page_i[L2_IDX_W-1:0]];
      l2_page_rd_q <= l2_page_mem[virt_page_i[L2_IDX_W-1:0]];
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign phys_page_o    = page_q;
  assign offset_out_o   = offout_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_d |-> cmd_i.exec)
    else $error("result raised outside an execute cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && req_q == REQ_FILL) |=> l2_valid_q[$past(l2_idx)])
    else $error("fill left its L2 line invalid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && req_q == REQ_TRANSLATE && !l1_hit && l2_hit) |-> l1_we)
    else $error("L2 hit without L1 refill");

endmodule

[sv/two_level_tlb_hierarchy.sv]
`timescale 1ns / 1ps
// Timing: a request is captured together with the registered read of the L2
// memory, then the execute state computes the result, and the result register
// raises the result strobe once the sequencer is back in idle.
// A new request is taken only in idle, never while the execute state is busy.
// Reset clears all valid bits at once; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
// two_level_tlb_hierarchy
// Instruction L1, data L1 and shared L2 direct-mapped TLB with fill and flush.
// ----------------------------------------------------------------------------
module two_level_tlb_hierarchy
  import tlb2_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             req_type_i,
  input  logic                   access_kind_i,
  input  logic [VPN_BITS-1:0]    virt_page_i,
  input  logic [OFFSET_BITS-1:0] page_offset_i,
  input  logic [PPN_BITS-1:0]    walk_page_i,
  input  logic [1:0]             flush_target_i,
  output logic                   result_valid_o,
  output logic [2:0]             status_o,
  output logic                   hit_o,
  output logic [PPN_BITS-1:0]    phys_page_o,
  output logic [OFFSET_BITS-1:0] offset_out_o
);

  tlb2_cmd_t cmd;

  tlb2_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  tlb2_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .access_kind_i  (access_kind_i),
    .virt_page_i    (virt_page_i),
    .page_offset_i  (page_offset_i),
    .walk_page_i    (walk_page_i),
    .flush_target_i (flush_target_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .phys_page_o    (phys_page_o),
    .offset_out_o   (offset_out_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer accepted without going busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> (status_o == ST_L1_HIT || status_o == ST_L2_HIT))
    else $error("hit flagged on a non-hit status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_MISS) |-> (phys_page_o == '0 && !hit_o))
    else $error("miss carries a page");

endmodule
